FILE: design/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge outside reset
`define ASRT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge outside reset
`define ASRT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cxc_pkg.sv
// shared types and constants of the clause checker
`timescale 1ns / 1ps
package cxc_pkg;

  localparam int LIT_W = 14;
  localparam int CNT_W = 13;
  localparam logic [CNT_W-1:0] VAR_COUNT_RST = 13'd4096;

  typedef enum logic [1:0] {
    OP_ASSIGN = 2'd0,
    OP_OR     = 2'd1,
    OP_XOR    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // decoded literal: polarity and range check
  typedef struct packed {
    logic negative;
    logic valid;
  } lit_info_t;

endpackage

FILE: design/cxc_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module cxc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/cxc_lit_dec.sv
// literal decoder: magnitude, polarity, range check and store address
`timescale 1ns / 1ps
module cxc_lit_dec #(
  parameter int MAX_VARS = 4096,
  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
  input  logic signed [cxc_pkg::LIT_W-1:0] literal,
  input  logic [cxc_pkg::CNT_W-1:0]        var_count,
  output cxc_pkg::lit_info_t               info,
  output logic [AW-1:0]                    addr
);
  import cxc_pkg::*;

  localparam logic [31:0] MAX_U = 32'(MAX_VARS);

  logic [LIT_W-1:0] raw;
  logic [LIT_W-1:0] mag;
  logic             negative;
  logic             in_range;

  assign raw      = unsigned'(literal);
  assign negative = raw[LIT_W-1];
  // most negative code wraps to its own magnitude, as intended
  assign mag      = negative ? (LIT_W'(0) - raw) : raw;
  assign in_range = (mag != '0) && (mag <= {1'b0, var_count}) && (32'(mag) <= MAX_U);

  assign info.negative = negative;
  assign info.valid    = in_range;
  assign addr          = AW'(mag - LIT_W'(1));

endmodule

FILE: design/cnf_xor_clause_checker.sv
// top level of the cnf clause checker with or- and xor-clauses
`timescale 1ns / 1ps
// Checks a truth assignment against a stream of clause items, one result item
// per input item, at up to one item per clock. Each item passes an input
// register (literal decode, store read and assign write), a store-data stage
// (clause accumulate, verdict and sticky error update) and the output register.
// The one-cycle rate is set by the single read and single write port of the
// value store, each used at most once per item as it moves from the input
// stage to the data stage. Writes and reads happen in item order on those
// transfers, so an assign is seen by the very next item. Each stage stalls
// only when the stage after it is full and blocked, so new items are taken
// while a result waits. After reset the value store is cleared by a sweep,
// one entry per cycle, during which in_ready stays low; cfg writes are taken
// at any time.
module cnf_xor_clause_checker #(
  parameter int MAX_VARS = 4096,
  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: var_count
  input  logic                             cfg_wr_en,
  input  logic [cxc_pkg::CNT_W-1:0]        cfg_wr_data,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_op,
  input  logic signed [cxc_pkg::LIT_W-1:0] in_literal,
  input  logic                             in_clause_last,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_clause_done,
  output logic                             out_clause_ok,
  output logic                             out_all_ok,
  output logic                             out_bad_literal
);
  import cxc_pkg::*;

  // configuration register
  logic [CNT_W-1:0] var_count_r;

  // store clearing sweep after reset
  logic          clr_busy_r;
  logic [AW-1:0] clr_idx_r;

  // input stage
  logic                    a_valid_r;
  op_t                     a_op_r;
  logic signed [LIT_W-1:0] a_lit_r;
  logic                    a_last_r;
  lit_info_t               a_info;
  logic [AW-1:0]           a_addr;

  // store-data stage
  logic      b_valid_r;
  op_t       b_op_r;
  logic      b_last_r;
  lit_info_t b_info_r;
  logic      b_value;

  // clause state
  logic accum_r, accum_nxt;
  logic verdict_r, verdict_nxt;
  logic err_r, err_nxt;
  logic done_nxt, ok_nxt;
  logic truth;

  // output register
  logic out_valid_r;
  logic out_done_r, out_ok_r, out_all_r, out_bad_r;

  // stage enables: a stage moves on when the next one is empty or moving
  logic en_out, en_b, en_a, accept;

  // store ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_re;

  assign en_out   = !out_valid_r || out_ready;
  assign en_b     = !b_valid_r || en_out;
  assign en_a     = !a_valid_r || en_b;
  assign in_ready = en_a && !clr_busy_r;
  assign accept   = in_valid && in_ready;

  // config write, no handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= VAR_COUNT_RST;
    end else if (cfg_wr_en) begin
      var_count_r <= cfg_wr_data;
    end
  end

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == AW'(MAX_VARS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r   <= op_t'(in_op);
      a_lit_r  <= in_literal;
      a_last_r <= in_clause_last;
    end
  end

  cxc_lit_dec #(
    .MAX_VARS (MAX_VARS)
  ) u_dec (
    .literal   (a_lit_r),
    .var_count (var_count_r),
    .info      (a_info),
    .addr      (a_addr)
  );

  // store access happens as the item moves into the data stage
  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = en_b && a_valid_r && (a_op_r == OP_ASSIGN) && a_info.valid;
      ram_waddr = a_addr;
      ram_wdata = !a_info.negative;
    end
  end

  assign ram_re = en_b && a_valid_r && a_info.valid;

  cxc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VARS)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (a_addr),
    .rdata (b_value)
  );

  // data stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid_r) begin
      b_op_r   <= a_op_r;
      b_last_r <= a_last_r;
      b_info_r <= a_info;
    end
  end

  // literal truth, only meaningful for an in-range literal
  assign truth = b_info_r.valid && (b_value ^ b_info_r.negative);

  // clause accumulate, verdict and sticky error update
  always_comb begin
    accum_nxt   = accum_r;
    verdict_nxt = verdict_r;
    err_nxt     = err_r;
    done_nxt    = 1'b0;
    ok_nxt      = 1'b0;
    if (b_op_r != OP_CLEAR && !b_info_r.valid) begin
      err_nxt = 1'b1;
    end
    case (b_op_r)
      OP_ASSIGN: begin
        accum_nxt = accum_r;
      end
      OP_OR, OP_XOR: begin
        if (b_op_r == OP_OR) begin
          accum_nxt = accum_r | truth;
        end else begin
          accum_nxt = accum_r ^ truth;
        end
        if (b_last_r) begin
          done_nxt    = 1'b1;
          ok_nxt      = accum_nxt;
          verdict_nxt = verdict_r & accum_nxt;
          accum_nxt   = 1'b0;
        end
      end
      OP_CLEAR: begin
        verdict_nxt = 1'b1;
        accum_nxt   = 1'b0;
      end
      default: begin
        accum_nxt = accum_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r   <= 1'b0;
      verdict_r <= 1'b1;
      err_r     <= 1'b0;
    end else if (en_out && b_valid_r) begin
      accum_r   <= accum_nxt;
      verdict_r <= verdict_nxt;
      err_r     <= err_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && b_valid_r) begin
      out_done_r <= done_nxt;
      out_ok_r   <= ok_nxt;
      out_all_r  <= verdict_nxt;
      out_bad_r  <= err_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_clause_done = out_done_r;
  assign out_clause_ok   = out_ok_r;
  assign out_all_ok      = out_all_r;
  assign out_bad_literal = out_bad_r;

endmodule

FILE: design/cxc_checker.sv
// port-level assertions of the clause checker and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cxc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [1:0]                       in_op,
  input logic signed [cxc_pkg::LIT_W-1:0] in_literal,
  input logic                             in_clause_last,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_clause_done,
  input logic                             out_clause_ok,
  input logic                             out_all_ok,
  input logic                             out_bad_literal
);

  logic [cxc_pkg::LIT_W+2:0] in_bits;
  logic [3:0]                out_bits;
  logic                      in_wait;
  logic                      out_wait;
  logic                      ok_shown;
  logic                      fail_shown;
  logic                      bad_shown;
  logic                      bad_kept;

  assign in_bits    = {in_op, in_literal, in_clause_last};
  assign out_bits   = {out_clause_done, out_clause_ok, out_all_ok, out_bad_literal};
  assign in_wait    = in_valid && !in_ready;
  assign out_wait   = out_valid && !out_ready;
  assign ok_shown   = out_valid && out_clause_ok;
  assign fail_shown = out_valid && out_clause_done && !out_clause_ok;
  assign bad_shown  = out_valid && out_bad_literal;
  assign bad_kept   = !out_valid || out_bad_literal;

  // a clause verdict only comes with a closed clause
  `ASRT_IMP(a_ok_needs_done, clk, rst_n, ok_shown, out_clause_done, "ok without done")

  // a failed clause pulls the running verdict down
  `ASRT_IMP(a_fail_clears_all, clk, rst_n, fail_shown, !out_all_ok, "all_ok after fail")

  // the error flag does not drop while results follow back to back
  `ASRT_NXT(a_bad_sticky, clk, rst_n, bad_shown, bad_kept, "bad_literal dropped")

  // a stalled result holds
  `ASRT_NXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_bits), "result changed")

  // a waiting input item holds
  `ASRT_NXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_bits), "item changed")

endmodule

bind cnf_xor_clause_checker cxc_checker u_cxc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_op           (in_op),
  .in_literal      (in_literal),
  .in_clause_last  (in_clause_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_clause_done (out_clause_done),
  .out_clause_ok   (out_clause_ok),
  .out_all_ok      (out_all_ok),
  .out_bad_literal (out_bad_literal)
);

FILE: bench/cnf_xor_clause_checker_tb.sv
// self-checking bench for the cnf clause checker: directed and random items
`timescale 1ns / 1ps
module cnf_xor_clause_checker_tb;
  import cxc_pkg::*;

  // quiet cycles allowed before the run is declared hung; covers the
  // clearing sweep after reset plus long random stalls
  localparam int HANG_LIMIT = 20000;
  // settle time after the last result
  localparam int TAIL_CYCLES = 12;

  // tracks the expected verdict stream of the checker
  class clause_scoreboard;
    localparam int VAR_DEPTH = 4096;

    typedef struct {
      bit done;
      bit ok;
      bit all;
      bit bad;
    } verdict_t;

    bit          var_vals [VAR_DEPTH];
    bit          accum;
    bit          overall;
    bit          sticky_err;
    int unsigned var_count;
    verdict_t    verdict_q [$];
    int          errors;
    int          results;

    function new();
      foreach (var_vals[i]) var_vals[i] = 1'b0;
      accum      = 1'b0;
      overall    = 1'b1;
      sticky_err = 1'b0;
      var_count  = VAR_COUNT_RST;
      errors     = 0;
      results    = 0;
    endfunction

    function void set_var_count(logic [CNT_W-1:0] v);
      var_count = v;
    endfunction

    // apply one accepted item to the shadow state and queue its verdict
    function void note_item(op_t op, logic signed [LIT_W-1:0] lit, bit last);
      int       l;
      int       mag;
      bit       neg;
      bit       ok_lit;
      bit       truth;
      verdict_t v;
      l      = lit;
      neg    = (l < 0);
      mag    = neg ? -l : l;
      ok_lit = (mag != 0) && (mag <= var_count) && (mag <= VAR_DEPTH);
      truth  = 1'b0;
      v.done = 1'b0;
      v.ok   = 1'b0;
      if (op != OP_CLEAR && !ok_lit) sticky_err = 1'b1;
      if (ok_lit) truth = var_vals[mag-1] ^ neg;
      case (op)
        OP_ASSIGN: begin
          if (ok_lit) var_vals[mag-1] = !neg;
        end
        OP_OR, OP_XOR: begin
          if (ok_lit) accum = (op == OP_OR) ? (accum | truth) : (accum ^ truth);
          if (last) begin
            v.done  = 1'b1;
            v.ok    = accum;
            overall = overall & accum;
            accum   = 1'b0;
          end
        end
        default: begin
          overall = 1'b1;
          accum   = 1'b0;
        end
      endcase
      v.all = overall;
      v.bad = sticky_err;
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    function void check_result(bit done, bit ok, bit all, bit bad);
      verdict_t v;
      results++;
      if (verdict_q.size() == 0) begin
        $error("result item with no pending verdict");
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (done !== v.done) begin
        $error("clause_done mismatch: expected %0b, got %0b", v.done, done);
        errors++;
      end
      if (ok !== v.ok) begin
        $error("clause_ok mismatch: expected %0b, got %0b", v.ok, ok);
        errors++;
      end
      if (all !== v.all) begin
        $error("all_ok mismatch: expected %0b, got %0b", v.all, all);
        errors++;
      end
      if (bad !== v.bad) begin
        $error("bad_literal mismatch: expected %0b, got %0b", v.bad, bad);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    cfg_wr_en       = 1'b0;
  logic [CNT_W-1:0]        cfg_wr_data     = '0;
  logic                    in_valid        = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_op           = OP_ASSIGN;
  logic signed [LIT_W-1:0] in_literal      = '0;
  logic                    in_clause_last  = 1'b0;
  logic                    out_valid;
  logic                    out_ready       = 1'b0;
  logic                    out_clause_done;
  logic                    out_clause_ok;
  logic                    out_all_ok;
  logic                    out_bad_literal;

  clause_scoreboard sb;

  // idle percentages of the two sides, set per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // shadow of the programmed var_count, used to aim random literals
  int cur_var_count = VAR_COUNT_RST;
  int items_sent    = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  cnf_xor_clause_checker #(
    .MAX_VARS(4096)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_literal     (in_literal),
    .in_clause_last (in_clause_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_clause_done(out_clause_done),
    .out_clause_ok  (out_clause_ok),
    .out_all_ok     (out_all_ok),
    .out_bad_literal(out_bad_literal)
  );

  always #6 clk = ~clk;

  // receiver side: random backpressure, one decision per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor: every accepted result goes straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_clause_done, out_clause_ok, out_all_ok, out_bad_literal);
    end
  end

  // hang detector: counts cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", HANG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // geometric gap length from the sender idle percentage, capped
  function automatic int pick_gap();
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    return gap;
  endfunction

  // a literal mostly inside the live variable range, sometimes just past it
  function automatic int pick_literal();
    int span;
    int var_no;
    span = (cur_var_count > 4096) ? 4096 : cur_var_count;
    if (span == 0) begin
      var_no = $urandom_range(3);
    end else if ($urandom_range(19) == 0) begin
      var_no = span + 1;
    end else if ($urandom_range(9) == 0) begin
      var_no = $urandom_range(span, 1);
    end else begin
      var_no = $urandom_range((span > 12) ? 12 : span, 1);
    end
    return $urandom_range(1) ? -var_no : var_no;
  endfunction

  // present one item, hold it until accepted, then note it
  task automatic drive_item(input op_t op, input int lit, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_literal     <= lit[LIT_W-1:0];
    in_clause_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, lit[LIT_W-1:0], last);
    items_sent++;
  endtask

  // stop sending until every queued verdict has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // single-cycle register write, only called while the block is idle
  task automatic write_var_count(input int v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[CNT_W-1:0];
    @(posedge clk);
    sb.set_var_count(v[CNT_W-1:0]);
    cur_var_count = v[CNT_W-1:0];
    cfg_writes++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // one clause of 1..4 literals: pure or, pure xor, or a mix of both
  task automatic send_clause();
    int  len;
    int  kind;
    op_t op;
    len  = $urandom_range(4, 1);
    kind = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) op = OP_OR;
      else if (kind == 1) op = OP_XOR;
      else op = $urandom_range(1) ? OP_OR : OP_XOR;
      drive_item(op, pick_literal(), (i == len - 1));
    end
  endtask

  // random traffic: mostly assigns and well-formed clauses, some clears and noise
  task automatic run_phase(input int var_count, input int s_pct, input int r_pct,
                           input int n_items);
    int  start;
    int  pick;
    bit  paused;
    write_var_count(var_count);
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < n_items) begin
      // mid-phase pause so the pipeline fully empties under traffic
      if (!paused && items_sent - start >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        drive_item(op_t'($urandom_range(3)), $urandom_range(16383), 1'($urandom_range(1)));
      end else if (pick < 17) begin
        drive_item(OP_CLEAR, $urandom_range(16383), 1'($urandom_range(1)));
      end else if (pick < 40) begin
        repeat ($urandom_range(3, 1)) begin
          drive_item(OP_ASSIGN, pick_literal(), 1'($urandom_range(1)));
        end
      end else begin
        send_clause();
      end
    end
    drain_results();
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, var_count above the store size acts as the store size
    write_var_count(8191);
    drive_item(OP_OR, 1, 1'b1);          // clause on an unset variable fails
    drive_item(OP_CLEAR, 0, 1'b1);       // clear restores the verdict, no clause closes
    drive_item(OP_ASSIGN, 1, 1'b1);      // last flag is ignored on assigns
    drive_item(OP_ASSIGN, 4096, 1'b0);   // top entry of the store
    drive_item(OP_ASSIGN, -2, 1'b0);
    drive_item(OP_OR, -1, 1'b0);
    drive_item(OP_OR, 4096, 1'b1);       // or clause satisfied
    drive_item(OP_XOR, 1, 1'b0);
    drive_item(OP_XOR, 4096, 1'b1);      // even parity fails the xor clause
    drive_item(OP_CLEAR, -1, 1'b0);
    drive_item(OP_XOR, 1, 1'b0);         // mixed or / xor clause
    drive_item(OP_OR, -2, 1'b0);
    drive_item(OP_XOR, -4096, 1'b1);
    drive_item(OP_ASSIGN, 8191, 1'b0);   // largest positive literal is out of range
    drive_item(OP_OR, 0, 1'b1);          // zero literal still closes the clause
    drive_item(OP_XOR, -8192, 1'b0);     // most negative literal
    drive_item(OP_OR, 4097, 1'b1);       // one past the store
    drive_item(OP_CLEAR, 0, 1'b0);       // sticky error survives a clear
    drain_results();

    // small var_count: one past the count and the store top are both bad
    write_var_count(8);
    drive_item(OP_OR, 9, 1'b0);
    drive_item(OP_OR, -8, 1'b1);
    drive_item(OP_ASSIGN, -3, 1'b0);
    drive_item(OP_XOR, 4096, 1'b1);
    drain_results();

    // random phases across var_count settings and idle patterns
    run_phase(8, 0, 0, 140);
    run_phase(1, 74, 0, 100);
    run_phase(5, 0, 74, 140);
    run_phase(4096, 31, 31, 140);
    run_phase(0, 0, 0, 40);
    run_phase(8191, 74, 0, 80);
    run_phase($urandom_range(30, 2), 31, 31, 160);

    recv_idle_pct <= 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d verdicts never arrived", sb.pending());
      sb.errors++;
    end

    $display("covered %0d items and %0d results over %0d var_count writes,",
             items_sent, sb.results, cfg_writes);
    $display("with or, xor, mixed and bad-literal clauses under four idle patterns");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: cnf_xor_clause_checker.f
+incdir+design
design/cxc_pkg.sv
design/cxc_ram.sv
design/cxc_lit_dec.sv
design/cnf_xor_clause_checker.sv
design/cxc_checker.sv
bench/cnf_xor_clause_checker_tb.sv
